@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the list RTL.
// Include this file by its bare name; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/blasr_pkg.sv @@
// Package for the bounded list unit: request codes, cell commands and cell status.
// Used by blasr_cell and bounded_list_add_search_remove_unit; depends on nothing.
`timescale 1ns / 1ps

package blasr_pkg;

  // Request codes carried on the input tuser.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_STRIKE,
    CELL_SHIFT
  } cell_op_e;

  // What a cell reports back to the controller.
  typedef struct packed {
    logic occ;
    logic hit;
    logic pull;
  } cell_stat_t;

endpackage

@@ rtl/blasr_cell.sv @@
// One storage cell of the list row: a value, an occupied flag and the local rules
// for append, strike and one-place compaction. Depends on blasr_pkg.
`timescale 1ns / 1ps

module blasr_cell
  import blasr_pkg::*;
#(
  parameter int VALUE_W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_op_e           op_i,
  input  logic [VALUE_W-1:0] key_i,
  input  logic               prev_occ_i,
  input  logic               next_occ_i,
  input  logic [VALUE_W-1:0] next_val_i,
  output logic [VALUE_W-1:0] val_o,
  output cell_stat_t         stat_o
);

  logic               occ_q, occ_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic               hit, pull, pushed;

  assign hit  = occ_q && (val_q == key_i);
  // An empty cell pulls the item above it down one place; the cell above then empties
  // unless it is itself pulling, which it cannot be while it is occupied.
  assign pull   = !occ_q && next_occ_i;
  assign pushed = !prev_occ_i && occ_q;

  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    case (op_i)
      CELL_LOAD: begin
        if (!occ_q && prev_occ_i) begin
          occ_d = 1'b1;
          val_d = key_i;
        end
      end
      CELL_STRIKE: begin
        if (hit) begin
          occ_d = 1'b0;
        end
      end
      CELL_SHIFT: begin
        if (pull) begin
          occ_d = 1'b1;
          val_d = next_val_i;
        end else if (pushed) begin
          occ_d = 1'b0;
        end
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o       = val_q;
  assign stat_o.occ  = occ_q;
  assign stat_o.hit  = hit;
  assign stat_o.pull = pull;

endmodule

@@ rtl/bounded_list_add_search_remove_unit.sv @@
// Top level of the bounded list unit: a row of blasr_cell instances and its controller.
// Depends on blasr_pkg, blasr_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The list holds up to CAPACITY values in insertion order, one value per cell of a row.
// Every request is accepted first; its result is loaded into the output register later,
// once no cell is still pulling and the output register is free. A remove strikes every
// matching cell in the accept cycle, after which the gaps bubble upwards one cell per
// cycle through neighbour-to-neighbour shifts, and its result waits for the last shift.
// One request is worked on at a time; the next is accepted as soon as the previous
// result has been placed in the output register, even while that result is still held.
module bounded_list_add_search_remove_unit
  import blasr_pkg::*;
#(
  parameter int CAPACITY    = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // element_value[31:0]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[0], found[1], match_index[4:2], entry_count[8:5], is_full[9], list_empty[10],
  // zero padding[15:11]
  output logic [15:0] m_axis_tdata
);

  localparam int CMP_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_X = (CNT_W > 4) ? CNT_W : 4;
  localparam int IDX_X = (IDX_W > 3) ? IDX_W : 3;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      req_q, req_d;
  logic [CMP_W-1:0] key_q, key_d;
  logic            status_q, status_d;
  logic            found_q, found_d;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     out_data_q, out_data_d;

  cell_op_e         cell_op;
  logic [CMP_W-1:0] key_bus;
  cell_stat_t       cell_stat [CAPACITY];
  logic [CMP_W-1:0] cell_val  [CAPACITY];
  logic [CAPACITY-1:0] occ_vec, hit_vec, pull_vec;
  logic [CAPACITY:0]   occ_ext;
  logic                any_pull, any_hit, is_full, list_empty;
  logic [CNT_W-1:0]    cnt;
  logic [IDX_W-1:0]    first_idx;
  logic [CNT_X-1:0]    cnt_ext;
  logic [IDX_X-1:0]    idx_ext;
  logic                in_accept, add_accept, search_accept, occ_is_thermo;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign add_accept    = in_accept && (s_axis_tuser == REQ_ADD);
  assign search_accept = in_accept && (s_axis_tuser == REQ_SEARCH);

  // The incoming value drives the row in the accept cycle, the held one afterwards.
  assign key_bus = (state_q == S_IDLE) ? s_axis_tdata[CMP_W-1:0] : key_q;

  always_comb begin
    cell_op = CELL_HOLD;
    if (state_q == S_RUN) begin
      cell_op = CELL_SHIFT;
    end else if (in_accept) begin
      case (s_axis_tuser)
        REQ_ADD:    cell_op = CELL_LOAD;
        REQ_REMOVE: cell_op = CELL_STRIKE;
        default:    cell_op = CELL_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic             prev_occ, next_occ;
    logic [CMP_W-1:0] next_val;

    if (g == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = cell_stat[g-1].occ;
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_occ = 1'b0;
      assign next_val = '0;
    end else begin : g_inner
      assign next_occ = cell_stat[g+1].occ;
      assign next_val = cell_val[g+1];
    end

    blasr_cell #(
      .VALUE_W (CMP_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (cell_op),
      .key_i      (key_bus),
      .prev_occ_i (prev_occ),
      .next_occ_i (next_occ),
      .next_val_i (next_val),
      .val_o      (cell_val[g]),
      .stat_o     (cell_stat[g])
    );
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ_vec[i]  = cell_stat[i].occ;
      hit_vec[i]  = cell_stat[i].hit;
      pull_vec[i] = cell_stat[i].pull;
    end
  end

  assign occ_ext  = {1'b0, occ_vec};
  assign any_pull = |pull_vec;
  assign any_hit  = |hit_vec;
  assign is_full  = occ_vec[CAPACITY-1];
  assign list_empty = !occ_vec[0];
  assign occ_is_thermo = ((occ_vec & (occ_vec + 1'b1)) == '0);

  // Once compaction has settled the occupied cells form a run from cell 0, so the
  // count is one past the last occupied cell.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (occ_ext[i] && !occ_ext[i+1]) begin
        cnt = cnt | CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign cnt_ext = CNT_X'(cnt);
  assign idx_ext = IDX_X'(first_idx);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    key_d       = key_q;
    status_d    = status_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d    = s_axis_tuser;
          key_d    = s_axis_tdata[CMP_W-1:0];
          status_d = add_accept && is_full;
          found_d  = (s_axis_tuser == REQ_REMOVE) && any_hit;
          state_d  = S_RUN;
        end
      end
      S_RUN: begin
        if (!any_pull && (!out_valid_q || m_axis_tready)) begin
          out_data_d        = '0;
          out_data_d[0]     = status_q;
          if (req_q == REQ_SEARCH) begin
            out_data_d[1]   = any_hit;
            out_data_d[4:2] = any_hit ? idx_ext[2:0] : 3'd0;
          end else if (req_q == REQ_REMOVE) begin
            out_data_d[1]   = found_q;
          end
          out_data_d[8:5]   = cnt_ext[3:0];
          out_data_d[9]     = is_full;
          out_data_d[10]    = list_empty;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= REQ_ADD;
      key_q       <= '0;
      status_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      key_q       <= key_d;
      status_q    <= status_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Between requests the occupied cells must be packed down from cell 0.
  `ASSERT_IMPLY(a_packed_when_idle, clk_i, rst_ni, state_q == S_IDLE, occ_is_thermo)
  // An add to a list with room occupies exactly one more cell.
  `ASSERT_NEXT(a_add_grows, clk_i, rst_ni, add_accept && !is_full,
               $countones(occ_vec) == $past($countones(occ_vec)) + 1)
  // A search leaves the occupancy of the row untouched.
  `ASSERT_NEXT(a_search_keeps, clk_i, rst_ni, search_accept, $stable(occ_vec))

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bounded_list_add_search_remove_unit: directed and random
// add, search and remove requests, each result checked against a list kept in step here.
// Depends on blasr_pkg and the unit RTL.
module testbench
  import blasr_pkg::*;
();

  localparam int         CAPACITY     = 8;
  localparam logic [1:0] REQ_SPARE    = 2'd3;
  localparam int         N_RANDOM     = 1030;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 2 * CAPACITY + 4;
  localparam int         POOL_SIZE    = 6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } list_req_t;

  // Same layout as the result tdata, lowest bit last.
  typedef struct packed {
    logic [4:0] pad;
    logic       empty;
    logic       full;
    logic [3:0] count;
    logic [2:0] index;
    logic       found;
    logic       status;
  } list_resp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // element_value[31:0]
  logic [1:0]  s_axis_tuser  = '0;  // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[0], found[1], match_index[4:2], entry_count[8:5], is_full[9], list_empty[10]
  logic [15:0] m_axis_tdata;

  logic [31:0] list_vals [CAPACITY];
  int          list_len = 0;
  logic [31:0] value_pool [POOL_SIZE];

  list_req_t   req_pending [$];
  list_resp_t  resp_expected [$];

  int          err_count    = 0;
  int          n_accepted   = 0;
  int          n_checked    = 0;
  int          n_refused    = 0;
  int          n_matched    = 0;
  int          n_issued     = 0;
  int          total_items  = 0;
  int          stall_cycles = 0;
  logic [1:0]  idle_phase   = 2'd0;

  bounded_list_add_search_remove_unit #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (32)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    err_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic queue_req(input logic [1:0] kind, input logic [31:0] value);
    list_req_t rq;
    rq.kind  = kind;
    rq.value = value;
    req_pending.push_back(rq);
  endtask

  // Applies one request to the local copy of the list and returns its result.
  function automatic list_resp_t apply_list_request(input list_req_t rq);
    list_resp_t r;
    int         kept;
    r = '0;
    case (rq.kind)
      REQ_ADD: begin
        if (list_len < CAPACITY) begin
          list_vals[list_len] = rq.value;
          list_len++;
        end else begin
          r.status = 1'b1;
        end
      end
      REQ_SEARCH: begin
        // Scanning downwards leaves the lowest matching index behind.
        for (int i = list_len - 1; i >= 0; i--) begin
          if (list_vals[i] == rq.value) begin
            r.found = 1'b1;
            r.index = 3'(i);
          end
        end
      end
      REQ_REMOVE: begin
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == rq.value) begin
            r.found = 1'b1;
          end else begin
            list_vals[kept] = list_vals[i];
            kept++;
          end
        end
        list_len = kept;
      end
      default: ;
    endcase
    r.count = 4'(list_len);
    r.full  = (list_len == CAPACITY);
    r.empty = (list_len == 0);
    return r;
  endfunction

  // Most values come from a small pool so that searches and removes find matches.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 70) begin
      return value_pool[$urandom_range(POOL_SIZE - 1)];
    end
    return $urandom();
  endfunction

  function automatic int idle_pct(input bit sender, input logic [1:0] phase);
    case (phase)
      2'd0:    return sender ? 21 : 68;
      2'd1:    return sender ? 68 : 21;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (req_pending.size() != 0 && $urandom_range(99) >= idle_pct(1'b1, idle_phase)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req_pending[0].kind;
        s_axis_tdata  <= req_pending[0].value;
        void'(req_pending.pop_front());
        n_issued++;
        if (n_issued * 3 < total_items) begin
          idle_phase <= 2'd0;
        end else if (n_issued * 3 < 2 * total_items) begin
          idle_phase <= 2'd1;
        end else begin
          idle_phase <= 2'd2;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0, idle_phase));
    end
  end

  // Results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    list_resp_t got;
    list_resp_t want;
    list_req_t  rq;
    if (!rst_ni) begin
      list_len = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (resp_expected.size() == 0) begin
          report_error($sformatf("result 0x%04h arrived with no request outstanding",
                                 m_axis_tdata));
        end else begin
          want = resp_expected.pop_front();
          n_checked++;
          compare_field("status", got.status, want.status);
          compare_field("found", got.found, want.found);
          compare_field("match_index", got.index, want.index);
          compare_field("entry_count", got.count, want.count);
          compare_field("is_full", got.full, want.full);
          compare_field("list_empty", got.empty, want.empty);
          compare_field("padding", got.pad, want.pad);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rq.kind  = s_axis_tuser;
        rq.value = s_axis_tdata;
        want = apply_list_request(rq);
        n_refused += want.status;
        n_matched += want.found;
        n_accepted++;
        resp_expected.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved on either side for %0d cycles.", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int roll;
    int n;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int p = 2; p < POOL_SIZE; p++) begin
      value_pool[p] = $urandom();
    end

    // Empty list first, then fill with duplicates, overfill and take it apart again.
    queue_req(REQ_SEARCH, 32'h0000_0000);
    queue_req(REQ_REMOVE, 32'h0000_0005);
    queue_req(REQ_SPARE,  32'h0000_0001);
    queue_req(REQ_ADD,    32'h0000_0000);
    queue_req(REQ_ADD,    32'hFFFF_FFFF);
    queue_req(REQ_ADD,    32'h0000_1234);
    queue_req(REQ_ADD,    32'h0000_0000);
    queue_req(REQ_ADD,    32'hA5A5_A5A5);
    queue_req(REQ_ADD,    32'h5A5A_5A5A);
    queue_req(REQ_ADD,    32'h0000_1234);
    queue_req(REQ_ADD,    32'hDEAD_BEEF);
    queue_req(REQ_ADD,    32'h0000_0007);
    queue_req(REQ_SEARCH, 32'hDEAD_BEEF);
    queue_req(REQ_SEARCH, 32'h0000_0000);
    queue_req(REQ_SEARCH, 32'h0000_1234);
    queue_req(REQ_SPARE,  32'hFFFF_FFFF);
    queue_req(REQ_SEARCH, 32'h0000_0063);
    queue_req(REQ_REMOVE, 32'h0000_0000);
    queue_req(REQ_REMOVE, 32'h0000_1234);
    queue_req(REQ_SEARCH, 32'hFFFF_FFFF);
    queue_req(REQ_REMOVE, 32'hFFFF_FFFF);
    queue_req(REQ_REMOVE, 32'hA5A5_A5A5);
    queue_req(REQ_REMOVE, 32'h5A5A_5A5A);
    queue_req(REQ_REMOVE, 32'hDEAD_BEEF);

    n = 0;
    while (n < N_RANDOM) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        // Sweep the whole pool away so the list is regularly cleared of every pool value.
        for (int p = 0; p < POOL_SIZE; p++) begin
          queue_req(REQ_REMOVE, value_pool[p]);
        end
        n += POOL_SIZE;
      end else begin
        if (roll < 48) begin
          queue_req(REQ_ADD, pick_value());
        end else if (roll < 73) begin
          queue_req(REQ_SEARCH, pick_value());
        end else if (roll < 95) begin
          queue_req(REQ_REMOVE, pick_value());
        end else begin
          queue_req(REQ_SPARE, pick_value());
        end
        n++;
      end
    end
    total_items = req_pending.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_pending.size() != 0 || s_axis_tvalid || resp_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results under three idling patterns.",
             n_accepted, n_checked);
    $display("Adds refused on a full list: %0d; searches and removes that matched: %0d.",
             n_refused, n_matched);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/blasr_pkg.sv
rtl/blasr_cell.sv
rtl/bounded_list_add_search_remove_unit.sv
tb/testbench.sv
